FILE: src/tfd_pkg.sv
// Package: shared types, constants and conversion functions for the texel decoder.
package tfd_pkg;

  typedef enum logic [1:0] {
    FMT_HALF  = 2'd0,
    FMT_UNORM = 2'd1,
    FMT_NONE  = 2'd2,
    FMT_RSVD  = 2'd3
  } fmt_t;

  localparam int unsigned Lanes = 4;

  typedef logic [31:0] sgl_t;

  // Single-precision value of b/255, correctly rounded, for every byte.
  function automatic sgl_t unorm_bits(input logic [7:0] b);
    logic [5:0]  k;
    logic [39:0] num;
    logic [39:0] q;
    logic [39:0] r;
    logic [39:0] res;
    begin
      k = 6'd1;
      for (int i = 1; i < 8; i++) begin
        if (({32'd0, b} << k) < 40'd255) k = k + 6'd1;
      end
      num = {32'd0, b} << (6'd23 + k);
      q   = num / 40'd255;
      r   = num % 40'd255;
      if ((r << 1) > 40'd255) q = q + 40'd1;
      res = ({32'd0, 8'd126 - {2'd0, k}} << 23) + q;
      if (b == 8'd0) unorm_bits = 32'd0;
      else if (b == 8'd255) unorm_bits = 32'h3F80_0000;
      else unorm_bits = res[31:0];
    end
  endfunction

  // Byte-indexed constant table, evaluated at elaboration.
  typedef sgl_t unorm_tab_t [256];

  function automatic unorm_tab_t build_unorm_tab();
    unorm_tab_t t;
    begin
      for (int i = 0; i < 256; i++) t[i] = unorm_bits(i[7:0]);
      build_unorm_tab = t;
    end
  endfunction

  localparam unorm_tab_t UnormTab = build_unorm_tab();

endpackage

FILE: src/texel_to_float4_decoder_top.sv
// Top level: texel decoder with four lanes and a registered output stage.
// Usage:
//   Input channel texel_valid/texel_stall carries one 64-bit texel per transfer.
//   Output channel out_valid/out_stall carries red, green, blue and alpha bits.
//   Config channel cfg_valid/cfg_ready writes the 2-bit texel format; ready is
//   always high. Write it only while the block is idle.
//   Format 0 widens four half floats, 1 decodes four unorm bytes from the low
//   32 bits, anything else gives zeros.
// Output: an accepted texel's result is valid in the cycle after its transfer.
// Throughput: one texel per cycle unless the output is stalled while full; four lanes
//   decode the channels in parallel, set by the single output register stage.
// Reset: clears the format to half float and empties the output register.
// Stall: while the output is stalled and full the input is stalled too; the
//   held result stays stable until taken.
module texel_to_float4_decoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  texel_format,
  input  logic        texel_valid,
  output logic        texel_stall,
  input  logic [63:0] texel_bytes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] red_bits,
  output logic [31:0] green_bits,
  output logic [31:0] blue_bits,
  output logic [31:0] alpha_bits
);

  logic [1:0]    fmt;
  tfd_pkg::sgl_t lane_bits [tfd_pkg::Lanes];
  logic          take;

  assign cfg_ready   = 1'b1;
  assign texel_stall = out_valid & out_stall;
  assign take        = texel_valid & ~texel_stall;

  always_ff @(posedge clk) begin
    if (rst) fmt <= tfd_pkg::FMT_HALF;
    else if (cfg_valid) fmt <= texel_format;
  end

  for (genvar g = 0; g < tfd_pkg::Lanes; g++) begin : g_lane
    tfd_lane u_lane (
      .fmt     (fmt),
      .half    (texel_bytes[16*g +: 16]),
      .byte_in (texel_bytes[8*g +: 8]),
      .bits    (lane_bits[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (!texel_stall) out_valid <= texel_valid;
  end

  // Merge lanes into the output register.
  always_ff @(posedge clk) begin
    if (take) begin
      red_bits   <= lane_bits[0];
      green_bits <= lane_bits[1];
      blue_bits  <= lane_bits[2];
      alpha_bits <= lane_bits[3];
    end
  end

endmodule

FILE: src/tfd_lane.sv
// Module: one channel lane, widens a half float or looks up a unorm byte; other formats give zero.
module tfd_lane (
  input  logic [1:0]          fmt,
  input  logic [15:0]         half,
  input  logic [7:0]          byte_in,
  output tfd_pkg::sgl_t       bits
);

  logic        sgn;
  logic [4:0]  expo;
  logic [9:0]  frac;
  logic [3:0]  lz;
  logic [9:0]  nfrac;
  logic [7:0]  sexp;
  tfd_pkg::sgl_t hbits;

  assign sgn  = half[15];
  assign expo = half[14:10];
  assign frac = half[9:0];

  always_comb begin
    lz = 4'd10;
    for (int i = 0; i < 10; i++) begin
      if (frac[i]) lz = 4'(9 - i);
    end
  end

  assign nfrac = 10'(({1'b0, frac} << (lz + 4'd1)));
  assign sexp  = 8'd112 - 8'(lz);

  always_comb begin
    if (expo == 5'd0) begin
      if (frac == 10'd0) hbits = {sgn, 31'd0};
      else hbits = {sgn, sexp, nfrac, 13'd0};
    end else if (expo == 5'h1F) begin
      hbits = {sgn, 8'hFF, frac, 13'd0};
    end else begin
      hbits = {sgn, 8'({3'd0, expo} + 8'd112), frac, 13'd0};
    end
  end

  always_comb begin
    case (fmt)
      tfd_pkg::FMT_HALF:  bits = hbits;
      tfd_pkg::FMT_UNORM: bits = tfd_pkg::UnormTab[byte_in];
      default:            bits = '0;
    endcase
  end

endmodule

FILE: src/tfd_checker.sv
// Checker: port-level assertions for the texel decoder, bound to the top level.
module tfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        texel_valid,
  input logic        texel_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] red_bits
);

  a_fill: assert property (@(posedge clk) disable iff (rst)
    texel_valid && !texel_stall |=> out_valid)
    else $error("transfer in did not fill output");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(red_bits))
    else $error("stalled result changed");

  a_back: assert property (@(posedge clk) disable iff (rst)
    texel_stall |-> out_valid && out_stall)
    else $error("input stalled without full output");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    !texel_valid && !out_stall |=> !out_valid)
    else $error("result invented");

endmodule

bind texel_to_float4_decoder_top tfd_checker u_tfd_checker (
  .clk         (clk),
  .rst         (rst),
  .texel_valid (texel_valid),
  .texel_stall (texel_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .red_bits    (red_bits)
);

FILE: verif/texel_decode_checker.sv
// Checker: predicts decoded channels for each texel transfer and compares outputs.
`timescale 1ns / 1ps
module texel_decode_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  texel_format,
  input  logic        texel_valid,
  input  logic        texel_stall,
  input  logic [63:0] texel_bytes,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] red_bits,
  input  logic [31:0] green_bits,
  input  logic [31:0] blue_bits,
  input  logic [31:0] alpha_bits,
  output int          mismatches,
  output int          pending
);

  typedef struct packed {
    logic [31:0] red;
    logic [31:0] green;
    logic [31:0] blue;
    logic [31:0] alpha;
  } float4_t;

  float4_t        decoded_q[$];
  tfd_pkg::fmt_t  fmt_model;

  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic [31:0] sgn;
    logic [4:0]  ex;
    logic [9:0]  fr;
    logic [10:0] m;
    logic [31:0] sh;
    begin
      sgn = {h[15], 31'd0};
      ex  = h[14:10];
      fr  = h[9:0];
      if (ex == 5'd0) begin
        if (fr == 10'd0) return sgn;
        m  = {1'b0, fr};
        sh = 0;
        while (!m[10]) begin
          m  = m << 1;
          sh = sh + 1;
        end
        return sgn | ((32'd113 - sh) << 23) | ({22'd0, m[9:0]} << 13);
      end
      if (ex == 5'd31) return sgn | 32'h7F80_0000 | ({22'd0, fr} << 13);
      return sgn | (({27'd0, ex} + 32'd112) << 23) | ({22'd0, fr} << 13);
    end
  endfunction

  function automatic logic [31:0] byte_ratio(input logic [7:0] b);
    int unsigned k;
    longint unsigned num, q, r;
    begin
      if (b == 8'd0) return 32'd0;
      if (b == 8'd255) return 32'h3F80_0000;
      k = 1;
      while (((64'(b)) << k) < 255 && k < 8) k++;
      num = 64'(b) << (23 + k);
      q = num / 255;
      r = num % 255;
      if (2 * r > 255) q++;
      return 32'(((64'(126 - k)) << 23) + q);
    end
  endfunction

  function automatic float4_t decode_texel(input tfd_pkg::fmt_t f, input logic [63:0] w);
    logic [31:0] ch [4];
    begin
      for (int c = 0; c < 4; c++) begin
        if (f == tfd_pkg::FMT_HALF) ch[c] = widen_half(w[16*c +: 16]);
        else if (f == tfd_pkg::FMT_UNORM) ch[c] = byte_ratio(w[8*c +: 8]);
        else ch[c] = 32'd0;
      end
      return '{ch[0], ch[1], ch[2], ch[3]};
    end
  endfunction

  assign pending = decoded_q.size();

  always @(posedge clk) begin
    float4_t exp_v, got;
    if (rst) begin
      fmt_model  <= tfd_pkg::FMT_HALF;
      mismatches <= 0;
      decoded_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) fmt_model <= tfd_pkg::fmt_t'(texel_format);
      if (out_valid && !out_stall) begin
        got = '{red_bits, green_bits, blue_bits, alpha_bits};
        if (decoded_q.size() == 0) begin
          if (mismatches < 10) $display("unexpected output %h", got);
          mismatches <= mismatches + 1;
        end else begin
          exp_v = decoded_q.pop_front();
          if (exp_v !== got) begin
            if (mismatches < 10) $display("mismatch exp %h got %h", exp_v, got);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (texel_valid && !texel_stall)
        decoded_q = {decoded_q, decode_texel(fmt_model, texel_bytes)};
    end
  end

endmodule

FILE: verif/testbench.sv
// Testbench top: drives texels, format writes and output stalls, gives the verdict.
`timescale 1ns / 1ps
module testbench;

  logic clk = 0, rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] texel_format = '0;
  logic texel_valid = 0;
  logic texel_stall;
  logic [63:0] texel_bytes = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [31:0] red_bits, green_bits, blue_bits, alpha_bits;
  int mismatches, pending;
  bit hold_long = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  texel_to_float4_decoder_top u_dut (.*);

  texel_decode_checker u_chk (.*);

  always @(posedge clk) begin
    if (hold_long) out_stall <= 1;
    else if ($urandom_range(0, 3) == 0) out_stall <= $urandom_range(0, 1);
  end

  task automatic wait_drain();
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_format(input logic [1:0] f);
    cfg_valid    <= 1;
    texel_format <= f;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  task automatic send_texel(input logic [63:0] w);
    texel_valid <= 1;
    texel_bytes <= w;
    @(posedge clk);
    while (texel_stall) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_half();
    case ($urandom_range(0, 5))
      0: return {$urandom_range(0, 1) == 1, 5'd0, 10'($urandom)};
      1: return {$urandom_range(0, 1) == 1, 5'd31, 10'($urandom)};
      2: return {$urandom_range(0, 1) == 1, 15'd0};
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_burst(input int n);
    logic [63:0] w;
    int left;
    left = n;
    while (left > 0) begin
      for (int b = $urandom_range(1, 20); b > 0 && left > 0; b--) begin
        w = {pick_half(), pick_half(), pick_half(), pick_half()};
        if ($urandom_range(0, 4) == 0) w = {$urandom, $urandom};
        send_texel(w);
        left--;
      end
      if ($urandom_range(0, 1)) begin
        texel_valid <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    texel_valid <= 0;
  endtask

  initial begin
    logic [1:0] fmts [6] = '{tfd_pkg::FMT_HALF, tfd_pkg::FMT_UNORM, tfd_pkg::FMT_NONE,
                             tfd_pkg::FMT_RSVD, tfd_pkg::FMT_UNORM, tfd_pkg::FMT_HALF};
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_texel(64'h0000_8000_0001_8001);
    send_texel(64'h03FF_83FF_0200_7C00);
    send_texel(64'hFC00_7E00_FFFF_7BFF);
    send_texel(64'h3C00_BC00_0400_8400);
    send_texel('1);
    send_texel('0);
    texel_valid <= 0;
    wait_drain();
    write_format(tfd_pkg::FMT_UNORM);
    send_texel(64'hFFFF_FFFF_FF00_01FE);
    send_texel(64'h0000_0000_807F_0280);
    send_texel(64'hA5A5_A5A5_0302_0100);
    texel_valid <= 0;
    wait_drain();
    for (int i = 0; i < 256; i += 4) send_texel({$urandom, 8'(i + 3), 8'(i + 2), 8'(i + 1), 8'(i)});
    texel_valid <= 0;
    wait_drain();
    hold_long <= 1;
    fork
      random_burst(20);
      begin
        repeat (60) @(posedge clk);
        hold_long <= 0;
      end
    join
    wait_drain();
    for (int p = 0; p < 6; p++) begin
      write_format(fmts[p]);
      random_burst(260);
      wait_drain();
    end
    wait_drain();
    repeat (5) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("testbench: errors");
    $finish;
  end

endmodule

FILE: sim.f
src/tfd_pkg.sv
src/tfd_lane.sv
src/texel_to_float4_decoder_top.sv
src/tfd_checker.sv
verif/texel_decode_checker.sv
verif/testbench.sv
